FILE: rtl/core/bts_pkg.sv
// Shared types and constants of the bilinear texture sampler.
package bts_pkg;

    localparam int unsigned MAX_SIDE    = 256;
    localparam int unsigned SIDE_W      = 9;
    localparam int unsigned IDX_W       = 8;
    localparam int unsigned COORD_FRAC  = 16;
    localparam int unsigned COORD_W     = 17;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned STORE_DEPTH = 65536;
    localparam int unsigned TEXEL_W     = 24;
    localparam int unsigned WEIGHT_W    = 17;
    localparam int unsigned SCALED_W    = 25;
    localparam int unsigned PROD_W      = 24;
    localparam int unsigned CHAN_OUT_W  = 16;
    localparam int unsigned IN_DATA_W   = 80;
    localparam int unsigned OUT_DATA_W  = 48;
    localparam int unsigned CFG_IDX_W   = 2;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic {
        FILTER_NEAREST  = 1'b0,
        FILTER_BILINEAR = 1'b1
    } filter_t;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd2;

    localparam logic [SIDE_W-1:0]   SIDE_MAX_VAL = SIDE_W'(MAX_SIDE);
    localparam logic [COORD_W-1:0]  COORD_ONE    = COORD_W'(1 << COORD_FRAC);
    localparam logic [SCALED_W-1:0] ROUND_HALF   = SCALED_W'(1 << (COORD_FRAC - 1));
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1 << COORD_FRAC);
    localparam logic [PROD_W-1:0]   OUT_ROUND    = PROD_W'(128);

endpackage

FILE: rtl/core/bts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bts_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/bilinear_texture_sampler.sv
// Top level of the bilinear / nearest RGB8 texture sampler.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser: cmd; tdata: address, rgb, u, v
//  m_       | out | m_tvalid/m_tready  | tdata: out_red, out_green, out_blue
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (9 bits)
//
// Eight register stages, A to G and the output register M; one item per
// cycle while the output is not stalled. The four neighbour reads come from
// four copies of the texel store, each written by every write item, read in
// one stage. Nearest mode points all four reads at the one chosen texel.
// Every stage has its own valid bit and advances when the next stage is
// empty or advancing, so bubbles close up and a stall loses nothing.
// Reset clears the valid bits and restores the default configuration; the store is not cleared.
// Write items update the store in the read stage and leave no result.
module bilinear_texture_sampler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] texel_address, [23:16] red, [31:24] green, [39:32] blue,
    // [56:40] coord_u, [73:57] coord_v, [79:74] zero
    input  logic [bts_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] out_red, [31:16] out_green, [47:32] out_blue
    output logic [bts_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bts_pkg::SIDE_W-1:0]     cfg_data
);
    import bts_pkg::*;

    // ---------------- configuration registers
    logic [SIDE_W-1:0] width_reg, height_reg;
    filter_t           mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIDE_MAX_VAL;
            height_reg <= SIDE_MAX_VAL;
            mode_reg   <= FILTER_BILINEAR;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                CFG_FILTER_MODE:  mode_reg   <= filter_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    // ---------------- stage valids and flow control
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic e_valid_reg, f_valid_reg, g_valid_reg, m_valid_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_m;

    assign rdy_m = !m_valid_reg || m_tready;
    assign rdy_g = !g_valid_reg || rdy_m;
    assign rdy_f = !f_valid_reg || rdy_g;
    assign rdy_e = !e_valid_reg || rdy_f;
    assign rdy_d = !d_valid_reg || rdy_e;
    assign rdy_c = !c_valid_reg || rdy_d;
    assign rdy_b = !b_valid_reg || rdy_c;
    assign rdy_a = !a_valid_reg || rdy_b;
    assign s_tready = rdy_a;

    // ---------------- stage A: capture, saturate coords, clamp sizes
    cmd_t              a_cmd_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [TEXEL_W-1:0] a_rgb_reg;
    logic [COORD_W-1:0] a_u_reg, a_v_reg;
    logic [SIDE_W-1:0] a_w_reg, a_h_reg;
    filter_t           a_mode_reg;

    logic [COORD_W-1:0] u_in, v_in, a_u_next, a_v_next;
    logic [SIDE_W-1:0]  a_w_next, a_h_next;

    assign u_in = s_tdata[56:40];
    assign v_in = s_tdata[73:57];
    // anything with the integer bit set is at or above one
    assign a_u_next = u_in[COORD_W-1] ? COORD_ONE : u_in;
    assign a_v_next = v_in[COORD_W-1] ? COORD_ONE : v_in;
    assign a_w_next = (width_reg == '0) ? SIDE_W'(1) :
                      (width_reg > SIDE_MAX_VAL) ? SIDE_MAX_VAL : width_reg;
    assign a_h_next = (height_reg == '0) ? SIDE_W'(1) :
                      (height_reg > SIDE_MAX_VAL) ? SIDE_MAX_VAL : height_reg;

    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            a_cmd_reg  <= cmd_t'(s_tuser);
            a_addr_reg <= s_tdata[15:0];
            a_rgb_reg  <= {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
            a_u_reg    <= a_u_next;
            a_v_reg    <= a_v_next;
            a_w_reg    <= a_w_next;
            a_h_reg    <= a_h_next;
            a_mode_reg <= mode_reg;
        end
    end

    // ---------------- stage B: scale by texture size
    cmd_t               b_cmd_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic [TEXEL_W-1:0] b_rgb_reg;
    logic [SCALED_W-1:0] b_su_reg, b_sv_reg;
    logic [SIDE_W-1:0]  b_w_reg, b_h_reg;
    filter_t            b_mode_reg;
    logic [COORD_W+SIDE_W-1:0] su_full, sv_full;

    assign su_full = a_u_reg * a_w_reg;
    assign sv_full = a_v_reg * a_h_reg;

    always_ff @(posedge aclk) begin
        if (rdy_b) begin
            b_cmd_reg  <= a_cmd_reg;
            b_addr_reg <= a_addr_reg;
            b_rgb_reg  <= a_rgb_reg;
            b_su_reg   <= su_full[SCALED_W-1:0];
            b_sv_reg   <= sv_full[SCALED_W-1:0];
            b_w_reg    <= a_w_reg;
            b_h_reg    <= a_h_reg;
            b_mode_reg <= a_mode_reg;
        end
    end

    // ---------------- stage C: texel indices, edge clamp, fractions
    cmd_t               c_cmd_reg;
    logic [ADDR_W-1:0]  c_addr_reg;
    logic [TEXEL_W-1:0] c_rgb_reg;
    logic [SIDE_W-1:0]  c_w_reg;
    logic [IDX_W-1:0]   c_col0_reg, c_col1_reg, c_row0_reg, c_row1_reg;
    logic [IDX_W-1:0]   c_dx_reg, c_dy_reg;

    logic [SCALED_W-1:0] su_rnd, sv_rnd;
    logic [SIDE_W-1:0]   ci_raw, ri_raw, w_m1, h_m1, ci0, ri0, ci1, ri1;
    logic                bil;

    assign bil    = (b_mode_reg == FILTER_BILINEAR);
    assign su_rnd = b_su_reg + ROUND_HALF;
    assign sv_rnd = b_sv_reg + ROUND_HALF;
    // bilinear floors, nearest rounds half up
    assign ci_raw = bil ? b_su_reg[SCALED_W-1:COORD_FRAC] : su_rnd[SCALED_W-1:COORD_FRAC];
    assign ri_raw = bil ? b_sv_reg[SCALED_W-1:COORD_FRAC] : sv_rnd[SCALED_W-1:COORD_FRAC];
    assign w_m1   = b_w_reg - SIDE_W'(1);
    assign h_m1   = b_h_reg - SIDE_W'(1);
    assign ci0    = (ci_raw > w_m1) ? w_m1 : ci_raw;
    assign ri0    = (ri_raw > h_m1) ? h_m1 : ri_raw;
    // nearest keeps all taps on the chosen texel
    assign ci1    = !bil ? ci0 :
                    ((ci0 + SIDE_W'(1)) > w_m1) ? w_m1 : ci0 + SIDE_W'(1);
    assign ri1    = !bil ? ri0 :
                    ((ri0 + SIDE_W'(1)) > h_m1) ? h_m1 : ri0 + SIDE_W'(1);

    always_ff @(posedge aclk) begin
        if (rdy_c) begin
            c_cmd_reg  <= b_cmd_reg;
            c_addr_reg <= b_addr_reg;
            c_rgb_reg  <= b_rgb_reg;
            c_w_reg    <= b_w_reg;
            c_col0_reg <= ci0[IDX_W-1:0];
            c_col1_reg <= ci1[IDX_W-1:0];
            c_row0_reg <= ri0[IDX_W-1:0];
            c_row1_reg <= ri1[IDX_W-1:0];
            // zero fractions make nearest a full weight on one texel
            c_dx_reg   <= bil ? b_su_reg[COORD_FRAC-1:COORD_FRAC-8] : '0;
            c_dy_reg   <= bil ? b_sv_reg[COORD_FRAC-1:COORD_FRAC-8] : '0;
        end
    end

    // ---------------- stage D: row offsets and blend weights
    cmd_t                c_dummy_unused;
    cmd_t               d_cmd_reg;
    logic [ADDR_W-1:0]  d_addr_reg, d_r0w_reg, d_r1w_reg;
    logic [TEXEL_W-1:0] d_rgb_reg;
    logic [IDX_W-1:0]   d_col0_reg, d_col1_reg;
    logic [WEIGHT_W-1:0] d_w00_reg, d_w10_reg, d_w01_reg, d_w11_reg;

    logic [SIDE_W-1:0]      ndx, ndy, pdx, pdy;
    logic [2*SIDE_W-1:0]    w00_f, w10_f, w01_f, w11_f;
    logic [IDX_W+SIDE_W-1:0] r0w_f, r1w_f;

    assign c_dummy_unused = c_cmd_reg;
    assign pdx   = {1'b0, c_dx_reg};
    assign pdy   = {1'b0, c_dy_reg};
    assign ndx   = SIDE_MAX_VAL - pdx;
    assign ndy   = SIDE_MAX_VAL - pdy;
    assign w00_f = ndx * ndy;
    assign w10_f = pdx * ndy;
    assign w01_f = ndx * pdy;
    assign w11_f = pdx * pdy;
    assign r0w_f = c_row0_reg * c_w_reg;
    assign r1w_f = c_row1_reg * c_w_reg;

    always_ff @(posedge aclk) begin
        if (rdy_d) begin
            d_cmd_reg  <= c_dummy_unused;
            d_addr_reg <= c_addr_reg;
            d_rgb_reg  <= c_rgb_reg;
            d_col0_reg <= c_col0_reg;
            d_col1_reg <= c_col1_reg;
            d_r0w_reg  <= r0w_f[ADDR_W-1:0];
            d_r1w_reg  <= r1w_f[ADDR_W-1:0];
            d_w00_reg  <= w00_f[WEIGHT_W-1:0];
            d_w10_reg  <= w10_f[WEIGHT_W-1:0];
            d_w01_reg  <= w01_f[WEIGHT_W-1:0];
            d_w11_reg  <= w11_f[WEIGHT_W-1:0];
        end
    end

    // ---------------- stage E: linear addresses (wrap to 16 bits)
    cmd_t               e_cmd_reg;
    logic [ADDR_W-1:0]  e_a00_reg, e_a10_reg, e_a01_reg, e_a11_reg;
    logic [TEXEL_W-1:0] e_rgb_reg;
    logic [WEIGHT_W-1:0] e_w00_reg, e_w10_reg, e_w01_reg, e_w11_reg;

    always_ff @(posedge aclk) begin
        if (rdy_e) begin
            e_cmd_reg <= d_cmd_reg;
            e_a00_reg <= (d_cmd_reg == CMD_WRITE) ? d_addr_reg
                                                  : d_r0w_reg + ADDR_W'(d_col0_reg);
            e_a10_reg <= d_r0w_reg + ADDR_W'(d_col1_reg);
            e_a01_reg <= d_r1w_reg + ADDR_W'(d_col0_reg);
            e_a11_reg <= d_r1w_reg + ADDR_W'(d_col1_reg);
            e_rgb_reg <= d_rgb_reg;
            e_w00_reg <= d_w00_reg;
            e_w10_reg <= d_w10_reg;
            e_w01_reg <= d_w01_reg;
            e_w11_reg <= d_w11_reg;
        end
    end

    // ---------------- stage F: store access (four copies, shared write)
    logic               st_we;
    logic [TEXEL_W-1:0] t00, t10, t01, t11;
    cmd_t               f_cmd_reg;
    logic [WEIGHT_W-1:0] f_w00_reg, f_w10_reg, f_w01_reg, f_w11_reg;

    assign st_we = rdy_f && e_valid_reg && (e_cmd_reg == CMD_WRITE);

    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram00 (
        .aclk(aclk), .we(st_we), .waddr(e_a00_reg), .wdata(e_rgb_reg),
        .re(rdy_f), .raddr(e_a00_reg), .rdata(t00)
    );
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram10 (
        .aclk(aclk), .we(st_we), .waddr(e_a00_reg), .wdata(e_rgb_reg),
        .re(rdy_f), .raddr(e_a10_reg), .rdata(t10)
    );
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram01 (
        .aclk(aclk), .we(st_we), .waddr(e_a00_reg), .wdata(e_rgb_reg),
        .re(rdy_f), .raddr(e_a01_reg), .rdata(t01)
    );
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_ram11 (
        .aclk(aclk), .we(st_we), .waddr(e_a00_reg), .wdata(e_rgb_reg),
        .re(rdy_f), .raddr(e_a11_reg), .rdata(t11)
    );

    always_ff @(posedge aclk) begin
        if (rdy_f) begin
            f_cmd_reg <= e_cmd_reg;
            f_w00_reg <= e_w00_reg;
            f_w10_reg <= e_w10_reg;
            f_w01_reg <= e_w01_reg;
            f_w11_reg <= e_w11_reg;
        end
    end

    // ---------------- stage G: channel times weight, channel 0 is red
    logic [PROD_W-1:0] g_p00_reg [3];
    logic [PROD_W-1:0] g_p10_reg [3];
    logic [PROD_W-1:0] g_p01_reg [3];
    logic [PROD_W-1:0] g_p11_reg [3];
    logic [PROD_W-1:0] g_p00_next [3];
    logic [PROD_W-1:0] g_p10_next [3];
    logic [PROD_W-1:0] g_p01_next [3];
    logic [PROD_W-1:0] g_p11_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            g_p00_next[c] = PROD_W'(t00[TEXEL_W-1-8*c -: 8] * f_w00_reg);
            g_p10_next[c] = PROD_W'(t10[TEXEL_W-1-8*c -: 8] * f_w10_reg);
            g_p01_next[c] = PROD_W'(t01[TEXEL_W-1-8*c -: 8] * f_w01_reg);
            g_p11_next[c] = PROD_W'(t11[TEXEL_W-1-8*c -: 8] * f_w11_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_g) begin
            g_p00_reg <= g_p00_next;
            g_p10_reg <= g_p10_next;
            g_p01_reg <= g_p01_next;
            g_p11_reg <= g_p11_next;
        end
    end

    // ---------------- stage M: sum, round half up, output register
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [PROD_W-1:0]     chan_sum [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            chan_sum[c] = g_p00_reg[c] + g_p10_reg[c] + g_p01_reg[c] + g_p11_reg[c]
                        + OUT_ROUND;
            m_data_next[CHAN_OUT_W*c +: CHAN_OUT_W] = chan_sum[c][PROD_W-1:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_m) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- valid chain; write items drop out after the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy_a) a_valid_reg <= s_tvalid;
            if (rdy_b) b_valid_reg <= a_valid_reg;
            if (rdy_c) c_valid_reg <= b_valid_reg;
            if (rdy_d) d_valid_reg <= c_valid_reg;
            if (rdy_e) e_valid_reg <= d_valid_reg;
            if (rdy_f) f_valid_reg <= e_valid_reg;
            if (rdy_g) g_valid_reg <= f_valid_reg && (f_cmd_reg == CMD_SAMPLE);
            if (rdy_m) m_valid_reg <= g_valid_reg;
        end
    end

`ifndef SYNTHESIS
    a_store_write_only: assert property (@(posedge aclk) disable iff (!aresetn)
        st_we |-> (e_cmd_reg == CMD_WRITE) && e_valid_reg)
        else $error("store written by a sample item");

    a_weights_unity: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg && (d_cmd_reg == CMD_SAMPLE) |->
            (d_w00_reg + d_w10_reg + d_w01_reg + d_w11_reg) == WEIGHT_ONE)
        else $error("blend weights do not sum to one");

    a_col_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && (c_cmd_reg == CMD_SAMPLE) |->
            ({1'b0, c_col1_reg} < c_w_reg) && (c_col0_reg <= c_col1_reg))
        else $error("column index past the edge");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> a_valid_reg && b_valid_reg && m_valid_reg)
        else $error("input stalled with a free stage");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bilinear / nearest RGB8 texture sampler.
`timescale 1ns / 1ps

module testbench;
    import bts_pkg::*;

    localparam int unsigned TAIL_CYCLES = 16;   // pipeline is eight deep
    localparam int unsigned STALL_LIMIT = 5000; // cycles with no handshake
    localparam int unsigned PHASE_ITEMS = 250;
    localparam int unsigned N_PHASES    = 8;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        cmd_t                  cmd;
        logic [ADDR_W-1:0]     addr;
        logic [TEXEL_W-1:0]    rgb;     // red in the top byte
        logic [COORD_W-1:0]    u;
        logic [COORD_W-1:0]    v;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [SIDE_W-1:0]     reg_val;
        bit                    typed;   // want holds a hand-computed result
        logic [OUT_DATA_W-1:0] want;    // {blue, green, red}
    } script_row_t;

    localparam int unsigned N_ROWS = 24;

    // Hand-typed results come from rows where all weight lies on one texel,
    // so the answer is just that texel shifted by 8.
    script_row_t script [0:N_ROWS-1] = '{
        '{ROW_ITEM, CMD_WRITE,  16'd0,     24'hFF0080, 17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd0, 1'b1, 48'h8000_0000_FF00},
        '{ROW_ITEM, CMD_WRITE,  16'd65535, 24'h123456, 17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0},
        // exactly one, and far above one (saturates), land on the last texel
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd65536,  17'd65536,  CFG_IMAGE_WIDTH, 9'd0, 1'b1, 48'h5600_3400_1200},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'h1FFFF,  17'h1FFFF,  CFG_IMAGE_WIDTH, 9'd0, 1'b1, 48'h5600_3400_1200},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd32768,  17'd32768,  CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd128,    17'd65535,  CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0},
        '{ROW_CFG,  CMD_WRITE,  16'd0,     24'h0,      17'd0,      17'd0,      CFG_FILTER_MODE, 9'd0, 1'b0, 48'h0},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd0, 1'b1, 48'h8000_0000_FF00},
        // u at exactly one half, v just short of one half
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd32768,  17'd32767,  CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd65536,  17'd0,      CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0},
        // zero width acts as one, oversize height acts as the maximum
        '{ROW_CFG,  CMD_WRITE,  16'd0,     24'h0,      17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd0,   1'b0, 48'h0},
        '{ROW_CFG,  CMD_WRITE,  16'd0,     24'h0,      17'd0,      17'd0,      CFG_IMAGE_HEIGHT, 9'd511, 1'b0, 48'h0},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd65535,  17'd0,      CFG_IMAGE_WIDTH, 9'd0, 1'b1, 48'h8000_0000_FF00},
        '{ROW_CFG,  CMD_WRITE,  16'd0,     24'h0,      17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd1, 1'b0, 48'h0},
        '{ROW_CFG,  CMD_WRITE,  16'd0,     24'h0,      17'd0,      17'd0,      CFG_IMAGE_HEIGHT, 9'd1, 1'b0, 48'h0},
        '{ROW_CFG,  CMD_WRITE,  16'd0,     24'h0,      17'd0,      17'd0,      CFG_FILTER_MODE, 9'd1, 1'b0, 48'h0},
        // 1x1 texture: all four neighbours clamp onto texel 0
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd40000,  17'd50000,  CFG_IMAGE_WIDTH, 9'd0, 1'b1, 48'h8000_0000_FF00},
        '{ROW_CFG,  CMD_WRITE,  16'd0,     24'h0,      17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd3, 1'b0, 48'h0},
        '{ROW_CFG,  CMD_WRITE,  16'd0,     24'h0,      17'd0,      17'd0,      CFG_IMAGE_HEIGHT, 9'd2, 1'b0, 48'h0},
        '{ROW_ITEM, CMD_WRITE,  16'd5,     24'hFFFFFF, 17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd65536,  17'd65536,  CFG_IMAGE_WIDTH, 9'd0, 1'b1, 48'hFF00_FF00_FF00},
        '{ROW_ITEM, CMD_SAMPLE, 16'd0,     24'h0,      17'd21845,  17'd32768,  CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0},
        '{ROW_ITEM, CMD_WRITE,  16'd65535, 24'h000000, 17'd0,      17'd0,      CFG_IMAGE_WIDTH, 9'd0, 1'b0, 48'h0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // [15:0] texel_address, [23:16] red, [31:24] green, [39:32] blue,
    // [56:40] coord_u, [73:57] coord_v, [79:74] zero
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    // [0] cmd
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [15:0] out_red, [31:16] out_green, [47:32] out_blue
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [SIDE_W-1:0]     cfg_data  = '0;

    always #1 aclk = ~aclk;

    bilinear_texture_sampler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---- mirror of the block's state --------------------------------------
    logic [TEXEL_W-1:0]    texels      [STORE_DEPTH];
    bit                    texel_known [STORE_DEPTH];
    logic [SIDE_W-1:0]     width_reg  = SIDE_W'(256);
    logic [SIDE_W-1:0]     height_reg = SIDE_W'(256);
    filter_t               mode_reg   = FILTER_BILINEAR;

    logic [OUT_DATA_W-1:0] pending_colors [$];

    int unsigned n_errors    = 0;
    int unsigned n_writes    = 0;
    int unsigned n_samples   = 0;
    int unsigned n_results   = 0;
    int unsigned n_cfg       = 0;
    int unsigned idle_cycles = 0;
    bit          quiet       = 1'b0;  // no gaps on either side

    function automatic int unsigned eff_side(logic [SIDE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_SIDE) return MAX_SIDE;
        return s;
    endfunction

    function automatic int unsigned clamp_to(int unsigned i, int unsigned side);
        return (i > side - 1) ? side - 1 : i;
    endfunction

    // Four neighbour addresses and blend fractions of a sample. Nearest mode
    // gives zero fractions, which reduces the blend to the base texel << 8.
    function automatic void sample_taps(input logic [COORD_W-1:0] cu, cv,
                                        output logic [ADDR_W-1:0] tap [4],
                                        output int unsigned fx, fy);
        int unsigned w, h, u, v, su, sv, p, q, p1, q1;
        w = eff_side(width_reg);
        h = eff_side(height_reg);
        u = (cu > COORD_ONE) ? COORD_ONE : cu;
        v = (cv > COORD_ONE) ? COORD_ONE : cv;
        su = u * w;
        sv = v * h;
        if (mode_reg == FILTER_NEAREST) begin
            p  = clamp_to((su + 32768) >> COORD_FRAC, w);
            q  = clamp_to((sv + 32768) >> COORD_FRAC, h);
            p1 = p;
            q1 = q;
            fx = 0;
            fy = 0;
        end else begin
            p  = clamp_to(su >> COORD_FRAC, w);
            q  = clamp_to(sv >> COORD_FRAC, h);
            p1 = clamp_to(p + 1, w);
            q1 = clamp_to(q + 1, h);
            fx = (su >> 8) & 8'hFF;
            fy = (sv >> 8) & 8'hFF;
        end
        tap[0] = ADDR_W'(q * w + p);
        tap[1] = ADDR_W'(q * w + p1);
        tap[2] = ADDR_W'(q1 * w + p);
        tap[3] = ADDR_W'(q1 * w + p1);
    endfunction

    function automatic logic [OUT_DATA_W-1:0] blend_texels(logic [COORD_W-1:0] cu, cv);
        logic [ADDR_W-1:0]     tap [4];
        int unsigned           fx, fy, acc;
        int unsigned           wt  [4];
        logic [OUT_DATA_W-1:0] color;
        sample_taps(cu, cv, tap, fx, fy);
        wt[0] = (256 - fx) * (256 - fy);
        wt[1] = fx * (256 - fy);
        wt[2] = (256 - fx) * fy;
        wt[3] = fx * fy;
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += ((texels[tap[k]] >> (16 - 8 * c)) & 8'hFF) * wt[k];
            color[16*c +: 16] = 16'((acc + 128) >> 8);
        end
        return color;
    endfunction

    function automatic int unsigned gap_len();
        if (quiet) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // ---- driving ----------------------------------------------------------
    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic push_item(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [TEXEL_W-1:0] rgb,
                             logic [COORD_W-1:0] u, v, bit typed, logic [OUT_DATA_W-1:0] want);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, v, u, rgb[7:0], rgb[15:8], rgb[23:16], addr};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE) begin
            texels[addr]      = rgb;
            texel_known[addr] = 1'b1;
            n_writes++;
        end else begin
            pending_colors.push_back(typed ? want : blend_texels(u, v));
            n_samples++;
        end
    endtask

    // Loads any neighbour that was never written, then issues the sample.
    task automatic sample_at(logic [COORD_W-1:0] u, v, bit typed, logic [OUT_DATA_W-1:0] want);
        logic [ADDR_W-1:0] tap [4];
        int unsigned       fx, fy;
        sample_taps(u, v, tap, fx, fy);
        for (int k = 0; k < 4; k++)
            if (!texel_known[tap[k]])
                push_item(CMD_WRITE, tap[k], TEXEL_W'($urandom), '0, '0, 1'b0, '0);
        push_item(CMD_SAMPLE, '0, '0, u, v, typed, want);
    endtask

    // Drain, let writes clear the pipe, then write one register.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH: begin
                width_reg = val;
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = val;
            end
            default: begin
                mode_reg = filter_t'(val[0]);
            end
        endcase
        n_cfg++;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_W'($urandom);          // may exceed one
            1:       return COORD_ONE;
            2:       return '0;
            3:       return COORD_W'(32768);
            default: return COORD_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Result ready: random stalls, mostly short, now and then long.
    int unsigned ready_hold = 0;
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= ($urandom_range(0, 2) != 0);
            ready_hold <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 3);
        end
    end

    // Result checker: each result against the oldest expected color.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_colors.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result %h", m_tdata);
            end else begin
                logic [OUT_DATA_W-1:0] exp_c;
                exp_c = pending_colors.pop_front();
                for (int c = 0; c < 3; c++)
                    if (m_tdata[16*c +: 16] !== exp_c[16*c +: 16]) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("ERROR: result %0d channel %0d: expected %h got %h",
                                     n_results, c, exp_c[16*c +: 16], m_tdata[16*c +: 16]);
                    end
            end
        end
    end

    // Watchdog: a run of cycles with no handshake anywhere means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int unsigned       sent;
        logic [SIDE_W-1:0] pw, ph;
        bit                pm;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            if (script[r].kind == ROW_CFG)
                write_reg(script[r].reg_idx, script[r].reg_val);
            else if (script[r].cmd == CMD_WRITE)
                push_item(CMD_WRITE, script[r].addr, script[r].rgb, '0, '0, 1'b0, '0);
            else
                sample_at(script[r].u, script[r].v, script[r].typed, script[r].want);
        end

        // random phases; the first few pin the size and mode extremes
        for (int ph_i = 0; ph_i < N_PHASES; ph_i++) begin
            case (ph_i)
                0:       begin pw = 256; ph = 256; pm = 1; end
                1:       begin pw = 256; ph = 256; pm = 0; end
                2:       begin pw = 1;   ph = 1;   pm = 1; end
                3:       begin pw = 511; ph = 0;   pm = 0; end
                4:       begin pw = 2;   ph = 2;   pm = 1; end
                default: begin
                    pw = SIDE_W'($urandom);
                    ph = SIDE_W'($urandom);
                    pm = $urandom_range(0, 1);
                end
            endcase
            write_reg(CFG_IMAGE_WIDTH, pw);
            write_reg(CFG_IMAGE_HEIGHT, ph);
            write_reg(CFG_FILTER_MODE, SIDE_W'(pm));
            quiet = (ph_i % 3 == 2);
            // count every item sent, neighbour loads included
            sent  = n_writes + n_samples;
            while (n_writes + n_samples - sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 3)
                    push_item(CMD_WRITE, ADDR_W'($urandom), TEXEL_W'($urandom),
                              COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
                else
                    sample_at(rand_coord(), rand_coord(), 1'b0, '0);
            end
            quiet = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d texel writes, %0d samples, %0d results, %0d register writes",
                 n_writes, n_samples, n_results, n_cfg);
        $display("both filter modes, clamped sizes and coordinates, edge and corner texels");
        if (n_errors == 0 && pending_colors.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("mismatches: %0d", n_errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bts_pkg.sv
rtl/core/bts_ram.sv
rtl/core/bilinear_texture_sampler.sv
tb/testbench.sv
